>>> src/mipo_pkg.sv
`default_nettype none
package mipo_pkg;

	localparam int IQ_DEPTH = 4;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT  = 2'd2;

	localparam logic [7:0] TRACE_RED = 8'd255;

	// per-voxel classification made by the front end
	typedef struct packed {
		logic first;       // first slice: overwrite the pixel
		logic emit;        // last slice: pixel is complete
		logic frame_last;  // final pixel of the image
		logic mask;
	} flags_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_last;
	} pix_t;

endpackage
`default_nettype wire

>>> src/max_intensity_projection_overlay.sv
// Maximum intensity projection along z with a trace overlay in red.
//
// Input channel (in_valid / in_stall): one voxel and its trace_mask bit per
// transfer, raster order, x fastest, then y, then slice. Output channel
// (out_valid / out_stall): one interleaved RGB pixel per voxel of the last
// slice, frame_last set on the final pixel of the image. Voxels of earlier
// slices only update the plane store and give no output.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 plane width,
// 1 plane height, 2 slice count. Any valid write to one of these indices
// restarts the volume at its first voxel. Write only while the block is idle.
//
// Throughput: one voxel per cycle while out_stall is low, set by one read and
// one write per cycle on the plane memory (read-modify-write with write
// forwarding). Path: an accepted voxel goes through the input queue, the
// stage-1 registers with the plane read, and the output queue to out_valid.
// When out_stall holds, the output queue fills and in_stall rises after the
// in-flight voxels land in the queues; nothing is dropped.
// Reset clears the position counters and restores register defaults. The
// plane store has no clearing pass: the first slice writes every pixel.
`default_nettype none
module max_intensity_projection_overlay
	import mipo_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_SLICES = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            voxel,
	input  wire logic                  trace_mask,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [7:0]            red,
	output logic      [7:0]            green,
	output logic      [7:0]            blue,
	output logic                       frame_last
);

	localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW       = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int IQ_W     = AW + 8 + $bits(flags_t);
	localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);

	logic                         iq_push;
	logic                         iq_full;
	logic                         iq_pop;
	logic                         iq_empty;
	logic [IQ_CNT_W-1:0]          iq_count;
	logic [IQ_W-1:0]              iq_din;
	logic [IQ_W-1:0]              iq_dout;
	logic [AW-1:0]                f_addr;
	logic [7:0]                   f_voxel;
	flags_t                       f_flags;
	logic [AW-1:0]                b_addr;
	logic [7:0]                   b_voxel;
	flags_t                       b_flags;

	logic                         oq_push;
	logic                         oq_full;
	logic                         oq_pop;
	logic                         oq_empty;
	logic [OQ_CNT_W-1:0]          oq_count;
	pix_t                         oq_din;
	pix_t                         oq_dout;

	assign cfg_ready = 1'b1;

	mipo_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_SLICES (MAX_SLICES),
		.AW         (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.voxel      (voxel),
		.trace_mask (trace_mask),
		.q_full     (iq_full),
		.q_push     (iq_push),
		.q_addr     (f_addr),
		.q_voxel    (f_voxel),
		.q_flags    (f_flags)
	);

	assign in_stall = iq_full;
	assign iq_din   = {f_addr, f_voxel, f_flags};

	mipo_fifo #(
		.WIDTH (IQ_W),
		.DEPTH (IQ_DEPTH)
	) u_iq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (iq_push),
		.din    (iq_din),
		.full   (iq_full),
		.pop    (iq_pop),
		.dout   (iq_dout),
		.empty  (iq_empty),
		.count  (iq_count)
	);

	assign {b_addr, b_voxel, b_flags} = iq_dout;

	mipo_back #(
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (iq_empty),
		.q_addr   (b_addr),
		.q_voxel  (b_voxel),
		.q_flags  (b_flags),
		.q_pop    (iq_pop),
		.oq_count (oq_count),
		.oq_push  (oq_push),
		.oq_pix   (oq_din)
	);

	mipo_fifo #(
		.WIDTH ($bits(pix_t)),
		.DEPTH (OQ_DEPTH)
	) u_oq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.din    (oq_din),
		.full   (oq_full),
		.pop    (oq_pop),
		.dout   (oq_dout),
		.empty  (oq_empty),
		.count  (oq_count)
	);

	assign out_valid  = !oq_empty;
	assign oq_pop     = out_valid && !out_stall;
	assign red        = oq_dout.red;
	assign green      = oq_dout.green;
	assign blue       = oq_dout.blue;
	assign frame_last = oq_dout.frame_last;

`ifndef NO_ASSERTIONS
	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(oq_push && oq_full && !oq_pop))
		else $error("output queue overflow");

	a_iq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		iq_pop |-> !iq_empty)
		else $error("input queue popped while empty");

	a_iq_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iq_full |-> (iq_count == IQ_CNT_W'(IQ_DEPTH)))
		else $error("input queue count out of range");

	a_pop_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(iq_pop && b_flags.emit && !oq_pop) |=> (oq_count != '0 || oq_push))
		else $error("emitting voxel lost between queues");
`endif

endmodule
`default_nettype wire

>>> src/mipo_ram.sv
`default_nettype none
module mipo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> src/mipo_fifo.sv
`default_nettype none
module mipo_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic [WIDTH-1:0]               din,
	output logic                                full,
	input  wire logic                           pop,
	output logic      [WIDTH-1:0]               dout,
	output logic                                empty,
	output logic      [$clog2(DEPTH + 1)-1:0]   count
);

	localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign dout  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign count = count_q;

endmodule
`default_nettype wire

>>> src/mipo_front.sv
`default_nettype none
module mipo_front
	import mipo_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_SLICES = 4096,
	parameter int AW         = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic [7:0]            voxel,
	input  wire logic                  trace_mask,
	input  wire logic                  q_full,
	output logic                       q_push,
	output logic      [AW-1:0]         q_addr,
	output logic      [7:0]            q_voxel,
	output flags_t                     q_flags
);

	localparam int CW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
	localparam int SW = MAX_SLICES > 1 ? $clog2(MAX_SLICES) : 1;

	localparam logic [CW-1:0] RST_W_LAST = CW'((MAX_WIDTH < 1024 ? MAX_WIDTH : 1024) - 1);
	localparam logic [RW-1:0] RST_H_LAST = RW'((MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024) - 1);

	logic [CW-1:0] w_last_q;
	logic [RW-1:0] h_last_q;
	logic [SW-1:0] s_last_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] slice_q;
	logic [AW-1:0] row_base_q;
	logic          accept;
	logic          cfg_hit;
	logic          last_col;
	logic          last_row;
	logic          last_slice;

	assign accept     = in_valid && !q_full;
	assign last_col   = (col_q == w_last_q);
	assign last_row   = (row_q == h_last_q);
	assign last_slice = (slice_q == s_last_q);

	always_comb begin
		unique case (cfg_index)
			REG_PLANE_WIDTH, REG_PLANE_HEIGHT, REG_SLICE_COUNT: cfg_hit = cfg_valid;
			default:                                            cfg_hit = 1'b0;
		endcase
	end

	// registers hold the clamped last index; zero acts as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= RST_W_LAST;
			h_last_q <= RST_H_LAST;
			s_last_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PLANE_WIDTH: begin
					if (cfg_data[10:0] == 11'd0) begin
						w_last_q <= '0;
					end else if (32'(cfg_data[10:0]) > 32'(MAX_WIDTH)) begin
						w_last_q <= CW'(MAX_WIDTH - 1);
					end else begin
						w_last_q <= CW'(cfg_data[10:0] - 11'd1);
					end
				end
				REG_PLANE_HEIGHT: begin
					if (cfg_data[10:0] == 11'd0) begin
						h_last_q <= '0;
					end else if (32'(cfg_data[10:0]) > 32'(MAX_HEIGHT)) begin
						h_last_q <= RW'(MAX_HEIGHT - 1);
					end else begin
						h_last_q <= RW'(cfg_data[10:0] - 11'd1);
					end
				end
				REG_SLICE_COUNT: begin
					if (cfg_data == 13'd0) begin
						s_last_q <= '0;
					end else if (32'(cfg_data) > 32'(MAX_SLICES)) begin
						s_last_q <= SW'(MAX_SLICES - 1);
					end else begin
						s_last_q <= SW'(cfg_data - 13'd1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// raster position; row base steps by the store's row pitch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			slice_q    <= '0;
			row_base_q <= '0;
		end else if (cfg_hit) begin
			col_q      <= '0;
			row_q      <= '0;
			slice_q    <= '0;
			row_base_q <= '0;
		end else if (accept) begin
			if (!last_col) begin
				col_q <= col_q + CW'(1);
			end else begin
				col_q <= '0;
				if (!last_row) begin
					row_q      <= row_q + RW'(1);
					row_base_q <= row_base_q + AW'(MAX_WIDTH);
				end else begin
					row_q      <= '0;
					row_base_q <= '0;
					slice_q    <= last_slice ? '0 : slice_q + SW'(1);
				end
			end
		end
	end

	assign q_push   = accept;
	assign q_addr   = row_base_q + AW'(col_q);
	assign q_voxel  = voxel;

	always_comb begin
		q_flags.first      = (slice_q == '0);
		q_flags.emit       = last_slice;
		q_flags.frame_last = last_col && last_row;
		q_flags.mask       = trace_mask;
	end

endmodule
`default_nettype wire

>>> src/mipo_back.sv
`default_nettype none
module mipo_back
	import mipo_pkg::*;
#(
	parameter int AW    = 20,
	parameter int DEPTH = 1048576
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  wire logic [AW-1:0]       q_addr,
	input  wire logic [7:0]          q_voxel,
	input  wire flags_t              q_flags,
	output logic                     q_pop,
	input  wire logic [OQ_CNT_W-1:0] oq_count,
	output logic                     oq_push,
	output pix_t                     oq_pix
);

	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    voxel_s1;
	flags_t        flags_s1;

	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic [7:0]    wr_data_q;

	logic [7:0]          rdata;
	logic [7:0]          stored;
	logic [7:0]          proj;
	logic [OQ_CNT_W:0]   pending;

	// reserve an output slot for every emitting voxel in flight
	assign pending = (OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(vld_s1 && flags_s1.emit);
	assign q_pop   = !q_empty && (32'(pending) < 32'(OQ_DEPTH));

	mipo_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_plane (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (addr_s1),
		.wdata (proj),
		.raddr (q_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			wr_vld_q <= 1'b0;
		end else begin
			vld_s1   <= q_pop;
			wr_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			addr_s1  <= q_addr;
			voxel_s1 <= q_voxel;
			flags_s1 <= q_flags;
		end
		wr_addr_q <= addr_s1;
		wr_data_q <= proj;
	end

	// the write of the previous cycle is not yet in the read data
	assign stored = (wr_vld_q && wr_addr_q == addr_s1) ? wr_data_q : rdata;
	assign proj   = (flags_s1.first || voxel_s1 > stored) ? voxel_s1 : stored;

	assign oq_push = vld_s1 && flags_s1.emit;

	always_comb begin
		oq_pix.red        = flags_s1.mask ? TRACE_RED : proj;
		oq_pix.green      = proj;
		oq_pix.blue       = proj;
		oq_pix.frame_last = flags_s1.frame_last;
	end

endmodule
`default_nettype wire

>>> tb/sv/tb_max_intensity_projection_overlay.sv
`timescale 1ns / 1ps

module tb_max_intensity_projection_overlay;
	import mipo_pkg::*;

	localparam int PLANE_MAX_W  = 1024;
	localparam int PLANE_MAX_H  = 1024;
	localparam int SLICES_MAX   = 4096;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT  = 1000;

	// index past the register list; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            voxel = '0;
	logic                  trace_mask = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;
	logic                  frame_last;

	max_intensity_projection_overlay dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.voxel      (voxel),
		.trace_mask (trace_mask),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.frame_last (frame_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// projection state mirrored from the accepted voxel stream
	bit [7:0]    proj_max [PLANE_MAX_W*PLANE_MAX_H];
	logic [9:0]  x_pos = '0;
	logic [9:0]  y_pos = '0;
	logic [11:0] z_pos = '0;
	logic [10:0] width_reg = 11'd1024;
	logic [10:0] height_reg = 11'd1024;
	logic [12:0] depth_reg = 13'd1;

	pix_t        pending_pixels [$];
	int          bad_pixels = 0;
	int unsigned voxels_sent = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int unsigned stall_left = 0;
	int unsigned quiet = 0;

	function automatic int unsigned eff_size(input int unsigned raw, input int unsigned hi);
		if (raw == 0)
			return 1;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	function automatic int unsigned volume_len();
		return eff_size(32'(width_reg), PLANE_MAX_W) * eff_size(32'(height_reg), PLANE_MAX_H) *
			eff_size(32'(depth_reg), SLICES_MAX);
	endfunction

	function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_PLANE_WIDTH: width_reg = val[10:0];
			REG_PLANE_HEIGHT: height_reg = val[10:0];
			REG_SLICE_COUNT: depth_reg = val;
			default: return;
		endcase
		x_pos = '0;
		y_pos = '0;
		z_pos = '0;
	endfunction

	function automatic void project_voxel(input logic [7:0] v, input logic m);
		int unsigned w;
		int unsigned h;
		int unsigned s;
		int unsigned addr;
		logic [7:0]  peak;
		logic        col_end;
		logic        row_end;
		logic        slice_end;
		pix_t        px;
		w = eff_size(32'(width_reg), PLANE_MAX_W);
		h = eff_size(32'(height_reg), PLANE_MAX_H);
		s = eff_size(32'(depth_reg), SLICES_MAX);
		if (x_pos >= w)
			x_pos = 10'(w - 1);
		if (y_pos >= h)
			y_pos = 10'(h - 1);
		if (z_pos >= s)
			z_pos = 12'(s - 1);
		addr = y_pos * PLANE_MAX_W + x_pos;
		// first slice overwrites, later slices only raise
		if (z_pos == 0 || v > proj_max[addr])
			proj_max[addr] = v;
		peak = proj_max[addr];
		col_end = (x_pos == w - 1);
		row_end = (y_pos == h - 1);
		slice_end = (z_pos == s - 1);
		if (slice_end) begin
			px.red = m ? TRACE_RED : peak;
			px.green = peak;
			px.blue = peak;
			px.frame_last = col_end && row_end;
			pending_pixels.push_back(px);
		end
		if (!col_end) begin
			x_pos++;
		end else begin
			x_pos = '0;
			if (!row_end) begin
				y_pos++;
			end else begin
				y_pos = '0;
				z_pos = slice_end ? '0 : z_pos + 12'd1;
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			bad_pixels++;
		end
	endfunction

	function automatic logic [7:0] pick_voxel();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel with none pending: red %0d green %0d blue %0d frame_last %0d",
					red, green, blue, frame_last);
				bad_pixels++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("frame_last", 8'(want.frame_last), 8'(frame_last));
			end
		end
	end

	// output backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left <= $urandom_range(15);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic set_idling(input int gap, input int stall);
		gap_pct <= gap;
		stall_pct <= stall;
	endtask

	task automatic pick_idling();
		case ($urandom_range(3))
			0: set_idling(0, 0);
			1: set_idling(10, 10);
			2: set_idling(40, 5);
			default: set_idling(5, 40);
		endcase
	endtask

	task automatic send_voxel(input logic [7:0] v, input logic m);
		int unsigned gap;
		if ($urandom_range(99) < gap_pct) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		voxel <= v;
		trace_mask <= m;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		project_voxel(v, m);
		voxels_sent++;
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count)
			send_voxel(pick_voxel(), 1'($urandom));
	endtask

	// all pixels out, then a settling wait for voxels that give none
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		load_register(idx, val);
	endtask

	task automatic set_volume(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input logic [CFG_DATA_W-1:0] s);
		write_reg(REG_PLANE_WIDTH, w);
		write_reg(REG_PLANE_HEIGHT, h);
		write_reg(REG_SLICE_COUNT, s);
	endtask

	// one slice by default: every voxel comes straight out
	task automatic test_reset_defaults();
		set_idling(20, 20);
		send_voxel(8'd0, 1'b0);
		send_voxel(8'd255, 1'b0);
		send_voxel(8'd0, 1'b1);
		send_voxel(8'd255, 1'b1);
		send_voxel(8'h55, 1'b0);
		send_voxel(8'hAA, 1'b1);
	endtask

	// zero sizes act as 1; upper data bits of width/height are dropped
	task automatic test_unit_volume();
		set_volume(13'h1800, 13'h1000, 13'd0);
		send_voxel(8'd77, 1'b0);
		send_voxel(8'd3, 1'b1);
	endtask

	task automatic test_small_volume();
		set_volume(13'd2, 13'd2, 13'd3);
		send_voxel(8'd10, 1'b1);
		send_voxel(8'd200, 1'b0);
		send_voxel(8'd0, 1'b0);
		send_voxel(8'd255, 1'b1);
		send_voxel(8'd20, 1'b0);
		send_voxel(8'd100, 1'b0);
		send_voxel(8'd0, 1'b1);
		send_voxel(8'd7, 1'b0);
		send_voxel(8'd20, 1'b0);
		send_voxel(8'd150, 1'b1);
		send_voxel(8'd1, 1'b0);
		send_voxel(8'd255, 1'b1);
		// wrapped into a new volume; spare index must not restart it
		send_voxel(8'd42, 1'b0);
		write_reg(REG_SPARE, 13'h1FFF);
		send_random(11);
	endtask

	// largest and clamped sizes; each volume is cut short by the next write
	task automatic test_size_extremes();
		set_idling(10, 10);
		set_volume(13'd1024, 13'd1, 13'd2);
		send_random(10);
		set_volume(13'd2047, 13'd1, 13'd1);
		send_random(10);
		set_volume(13'd1, 13'd1024, 13'd1);
		send_random(10);
		set_volume(13'd1, 13'd2047, 13'd1);
		send_random(10);
		set_volume(13'd1, 13'd1, 13'd4096);
		send_random(10);
		set_volume(13'd1, 13'd1, 13'd8191);
		send_random(10);
	endtask

	task automatic test_random_volumes();
		int unsigned start;
		int unsigned len;
		int unsigned part;
		int unsigned kind;
		start = voxels_sent;
		while (voxels_sent - start < 370) begin
			pick_idling();
			kind = $urandom_range(9);
			if (kind == 0) begin
				// arbitrary register contents, short stretch of voxels
				write_reg(CFG_IDX_W'($urandom), CFG_DATA_W'($urandom));
				send_random($urandom_range(1, 20));
			end else begin
				set_volume(CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom_range(0, 5)),
					CFG_DATA_W'($urandom_range(0, 4)));
				len = volume_len();
				if (kind == 1) begin
					// volume cut short; the next write restarts it
					send_random($urandom_range(1, len));
				end else if (kind == 2) begin
					part = $urandom_range(0, len);
					send_random(part);
					write_reg(REG_SPARE, CFG_DATA_W'($urandom));
					send_random(len - part);
				end else begin
					send_random(len * $urandom_range(1, 2));
				end
			end
		end
	endtask

	task automatic test_full_rate();
		set_idling(0, 0);
		set_volume(13'd4, 13'd3, 13'd2);
		send_random(3 * volume_len());
		set_volume(13'd5, 13'd1, 13'd1);
		send_random(2 * volume_len());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_unit_volume();
		test_small_volume();
		test_size_extremes();
		test_random_volumes();
		test_full_rate();
		drain();
		if (bad_pixels == 0 && pending_pixels.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
